### rtl/msrt_pkg.sv
// shared types, constants and crc function for the modbus sensor read transaction
package msrt_pkg;

   localparam int FRAME_LEN   = 8;
   localparam int RESP_LEN    = 11;
   localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
   localparam int RCNT_W      = $clog2(RESP_LEN);
   localparam int PAYLOAD_LEN = 7;

   localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
   localparam logic [15:0] START_REG      = 16'h0000;
   localparam logic [15:0] REG_COUNT      = 16'h0003;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   localparam logic [7:0]  DEV_ADDR_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_RX_BYTE = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_START   = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_CRC_ERR = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_RSVD    = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_DEV_ADDR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 1'b1;

   // frame byte positions
   localparam logic [FRAME_IDX_W-1:0] FB_ADDR     = 3'd0;
   localparam logic [FRAME_IDX_W-1:0] FB_FUNC     = 3'd1;
   localparam logic [FRAME_IDX_W-1:0] FB_START_HI = 3'd2;
   localparam logic [FRAME_IDX_W-1:0] FB_START_LO = 3'd3;
   localparam logic [FRAME_IDX_W-1:0] FB_COUNT_HI = 3'd4;
   localparam logic [FRAME_IDX_W-1:0] FB_COUNT_LO = 3'd5;
   localparam logic [FRAME_IDX_W-1:0] FB_CRC_LO   = 3'd6;
   localparam logic [FRAME_IDX_W-1:0] FB_CRC_HI   = 3'd7;

   typedef struct packed {
      logic              tx_valid;
      logic [7:0]        tx_byte;
      logic              tx_last;
      logic              done_res;
      logic [1:0]        status;
      logic [15:0]       moisture_tenths;
      logic signed [15:0] temperature_tenths;
      logic [15:0]       conductivity;
   } rsp_type;

   // modbus crc-16, one byte, reflected polynomial
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/msrt_if.sv
// handshake channel interfaces for request, response and csr write

interface msrt_req_if;
   import msrt_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] rx_byte;
   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface msrt_rsp_if;
   import msrt_pkg::*;
   logic               valid;
   logic               ready;
   logic               tx_valid;
   logic [7:0]         tx_byte;
   logic               tx_last;
   logic               done_res;
   logic [1:0]         status;
   logic [15:0]        moisture_tenths;
   logic signed [15:0] temperature_tenths;
   logic [15:0]        conductivity;
   modport source (output valid, output tx_valid, output tx_byte, output tx_last,
                   output done_res, output status, output moisture_tenths,
                   output temperature_tenths, output conductivity, input ready);
   modport sink   (input valid, input tx_valid, input tx_byte, input tx_last,
                   input done_res, input status, input moisture_tenths,
                   input temperature_tenths, input conductivity, output ready);
endinterface

interface msrt_csr_if;
   import msrt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/modbus_sensor_read_transaction.sv
// top level of the modbus rtu read holding registers transaction with crc-16
//
// channel  dir  transfer contents
// req_bus  in   command (rx byte / ms tick / start), rx_byte
// rsp_bus  out  tx byte with last flag, or done with status and three sensor words
// csr_bus  in   register index (0 device address, 1 timeout ms), write data
//
// a start launches the frame sequencer, which pushes the request bytes into the output one per cycle
// while the skid entry is empty
// synchronous active high reset clears the transaction state and restores csr defaults
// an output register plus one skid entry let a transfer be taken while a result waits
// req_bus.ready drops while the frame is sent or the skid entry is full
module modbus_sensor_read_transaction (
   input  logic           clock,
   input  logic           reset,
   msrt_req_if.sink       req_bus,
   msrt_rsp_if.source     rsp_bus,
   msrt_csr_if.sink       csr_bus
);
   import msrt_pkg::*;

   // configuration
   logic [7:0]  dev_addr_ff;
   logic [15:0] timeout_ff;

   // transaction state
   logic              busy_ff,  busy_in;
   logic [RCNT_W-1:0] rcnt_ff,  rcnt_in;
   logic [15:0]       crc_ff,   crc_in;
   logic [15:0]       elapsed_ff, elapsed_in;
   logic [7:0]        payload_ff [PAYLOAD_LEN];

   // request frame sequencer
   logic                   frame_active_ff, frame_active_in;
   logic [FRAME_IDX_W-1:0] frame_idx_ff,    frame_idx_in;
   logic [15:0]            tx_crc_ff,       tx_crc_in;

   // output register and skid entry
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff,       out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff,       skid_in;

   logic    req_take;
   logic    out_take;
   logic    item_push;
   rsp_type item_rsp;
   logic    frame_push;
   rsp_type frame_rsp;
   logic    push;
   rsp_type push_rsp;
   cmd_type cmd;
   logic [15:0] tick_elapsed;
   logic [15:0] rx_crc;
   logic [15:0] got_crc;
   logic        got_ok;
   logic [7:0]  frame_byte;

   assign cmd      = cmd_type'(req_bus.command);
   assign req_take = req_bus.valid && req_bus.ready;
   assign out_take = out_valid_ff && rsp_bus.ready;

   assign req_bus.ready = !frame_active_ff && !skid_valid_ff;
   assign csr_bus.ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEV_ADDR_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_DEV_ADDR: dev_addr_ff <= csr_bus.data[7:0];
            CSR_TIMEOUT:  timeout_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // response bytes and ticks
   assign tick_elapsed = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign rx_crc       = crc_byte(crc_ff, req_bus.rx_byte);
   assign got_crc      = {req_bus.rx_byte, payload_ff[PAYLOAD_LEN-1]};
   assign got_ok       = (got_crc == crc_ff);

   always_comb begin
      busy_in    = busy_ff;
      rcnt_in    = rcnt_ff;
      crc_in     = crc_ff;
      elapsed_in = elapsed_ff;
      item_push  = 1'b0;
      item_rsp   = '0;
      if (req_take) begin
         case (cmd)
            CMD_START: begin
               busy_in    = 1'b1;
               rcnt_in    = '0;
               crc_in     = CRC_INIT;
               elapsed_in = '0;
            end
            CMD_TICK: begin
               if (busy_ff) begin
                  elapsed_in = tick_elapsed;
                  if (tick_elapsed >= timeout_ff) begin
                     item_push       = 1'b1;
                     item_rsp.done_res = 1'b1;
                     item_rsp.status = ST_TIMEOUT;
                  end
               end
            end
            CMD_RX_BYTE: begin
               if (busy_ff) begin
                  if (elapsed_ff >= timeout_ff) begin
                     // late byte after the limit is dropped
                     item_push       = 1'b1;
                     item_rsp.done_res = 1'b1;
                     item_rsp.status = ST_TIMEOUT;
                  end else if (rcnt_ff >= RCNT_W'(RESP_LEN - 1)) begin
                     item_push         = 1'b1;
                     item_rsp.done_res = 1'b1;
                     if (got_ok) begin
                        item_rsp.status             = ST_OK;
                        item_rsp.moisture_tenths    = {payload_ff[0], payload_ff[1]};
                        item_rsp.temperature_tenths = {payload_ff[2], payload_ff[3]};
                        item_rsp.conductivity       = {payload_ff[4], payload_ff[5]};
                     end else begin
                        item_rsp.status = ST_CRC_ERR;
                     end
                  end else begin
                     // crc covers header and data bytes only
                     if (rcnt_ff < RCNT_W'(RESP_LEN - 2)) begin
                        crc_in = rx_crc;
                     end
                     rcnt_in = rcnt_ff + RCNT_W'(1);
                  end
               end
            end
            default: ;
         endcase
         if (item_push) begin
            busy_in    = 1'b0;
            rcnt_in    = '0;
            crc_in     = CRC_INIT;
            elapsed_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rcnt_ff    <= '0;
         crc_ff     <= CRC_INIT;
         elapsed_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         rcnt_ff    <= rcnt_in;
         crc_ff     <= crc_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // payload capture, response bytes 3 through 9
   always_ff @(posedge clock) begin
      if (req_take && cmd == CMD_RX_BYTE && busy_ff && elapsed_ff < timeout_ff) begin
         for (int i = 0; i < PAYLOAD_LEN; i++) begin
            if (rcnt_ff == RCNT_W'(i + 3)) begin
               payload_ff[i] <= req_bus.rx_byte;
            end
         end
      end
   end

   // request frame, one byte per cycle while the skid entry is empty, crc folded as bytes go out
   always_comb begin
      case (frame_idx_ff)
         FB_ADDR:     frame_byte = dev_addr_ff;
         FB_FUNC:     frame_byte = FUNC_READ_HOLD;
         FB_START_HI: frame_byte = START_REG[15:8];
         FB_START_LO: frame_byte = START_REG[7:0];
         FB_COUNT_HI: frame_byte = REG_COUNT[15:8];
         FB_COUNT_LO: frame_byte = REG_COUNT[7:0];
         FB_CRC_LO:   frame_byte = tx_crc_ff[7:0];
         default:     frame_byte = tx_crc_ff[15:8];
      endcase
   end

   assign frame_push = frame_active_ff && !skid_valid_ff;

   always_comb begin
      frame_rsp          = '0;
      frame_rsp.tx_valid = 1'b1;
      frame_rsp.tx_byte  = frame_byte;
      frame_rsp.tx_last  = (frame_idx_ff == FB_CRC_HI);
   end

   always_comb begin
      frame_active_in = frame_active_ff;
      frame_idx_in    = frame_idx_ff;
      tx_crc_in       = tx_crc_ff;
      if (req_take && cmd == CMD_START) begin
         frame_active_in = 1'b1;
         frame_idx_in    = '0;
         tx_crc_in       = CRC_INIT;
      end else if (frame_push) begin
         if (frame_idx_ff < FB_CRC_LO) begin
            tx_crc_in = crc_byte(tx_crc_ff, frame_byte);
         end
         if (frame_idx_ff == FB_CRC_HI) begin
            frame_active_in = 1'b0;
         end
         frame_idx_in = frame_idx_ff + FRAME_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
         frame_idx_ff    <= '0;
      end else begin
         frame_active_ff <= frame_active_in;
         frame_idx_ff    <= frame_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_crc_ff <= tx_crc_in;
   end

   // the frame and the item path never push in the same cycle
   assign push     = item_push || frame_push;
   assign push_rsp = frame_push ? frame_rsp : item_rsp;

   // output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || out_take) begin
            out_in       = push_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.tx_valid           = out_ff.tx_valid;
   assign rsp_bus.tx_byte            = out_ff.tx_byte;
   assign rsp_bus.tx_last            = out_ff.tx_last;
   assign rsp_bus.done_res           = out_ff.done_res;
   assign rsp_bus.status             = out_ff.status;
   assign rsp_bus.moisture_tenths    = out_ff.moisture_tenths;
   assign rsp_bus.temperature_tenths = out_ff.temperature_tenths;
   assign rsp_bus.conductivity       = out_ff.conductivity;

`ifndef NO_ASSERTIONS
   // skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output valid");

   // a start launches the frame from its first byte
   a_start_launch: assert property (@(posedge clock) disable iff (reset)
      (req_take && cmd == CMD_START) |=> (frame_active_ff && frame_idx_ff == FB_ADDR))
      else $error("start did not launch request frame");

   // response byte count never passes the final crc byte
   a_rcnt_range: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= RCNT_W'(RESP_LEN - 1))
      else $error("response byte count out of range");

   // a done result clears the transaction
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      item_push |=> (!busy_ff && rcnt_ff == '0 && elapsed_ff == '0))
      else $error("transaction state not cleared after done");
`endif

endmodule

### dv/modbus_sensor_read_transaction_test.sv
// testbench for the modbus sensor read transaction: random readings checked against a predictor
module modbus_sensor_read_transaction_test;
   timeunit 1ns;
   timeprecision 1ps;

   import msrt_pkg::*;

   // expected result store and a model of the transaction state
   class reading_scoreboard_type;
      logic [7:0]  dev_addr;
      logic [15:0] timeout_limit;
      bit          in_progress;
      int unsigned byte_count;
      logic [15:0] resp_crc;
      logic [7:0]  payload [8];
      logic [15:0] ms_count;
      rsp_type     expected_q [$];
      int unsigned error_count;
      int unsigned result_count;

      function new();
         dev_addr      = DEV_ADDR_RESET;
         timeout_limit = TIMEOUT_RESET;
         in_progress   = 1'b0;
         byte_count    = 0;
         resp_crc      = CRC_INIT;
         ms_count      = '0;
         error_count   = 0;
         result_count  = 0;
         foreach (payload[i]) payload[i] = '0;
      endfunction

      // bit-serial form of the reflected crc-16
      static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DEV_ADDR) begin
            dev_addr = data[7:0];
         end else if (idx == CSR_TIMEOUT) begin
            timeout_limit = data;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void close_reading(status_type st);
         rsp_type r;
         r = '0;
         r.done_res = 1'b1;
         r.status   = st;
         if (st == ST_OK) begin
            r.moisture_tenths    = {payload[0], payload[1]};
            r.temperature_tenths = {payload[2], payload[3]};
            r.conductivity       = {payload[4], payload[5]};
         end
         expected_q.push_back(r);
         in_progress = 1'b0;
         byte_count  = 0;
         resp_crc    = CRC_INIT;
         ms_count    = '0;
      endfunction

      // returns 1 when the transfer had any effect on the transaction
      function bit note_request(cmd_type c, logic [7:0] b);
         logic [7:0]  frame [FRAME_LEN];
         logic [15:0] crc;
         rsp_type     r;
         if (c == CMD_START) begin
            frame[0] = dev_addr;
            frame[1] = FUNC_READ_HOLD;
            frame[2] = START_REG[15:8];
            frame[3] = START_REG[7:0];
            frame[4] = REG_COUNT[15:8];
            frame[5] = REG_COUNT[7:0];
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++) crc = crc16_update(crc, frame[i]);
            frame[6] = crc[7:0];
            frame[7] = crc[15:8];
            for (int i = 0; i < FRAME_LEN; i++) begin
               r = '0;
               r.tx_valid = 1'b1;
               r.tx_byte  = frame[i];
               r.tx_last  = (i == FRAME_LEN - 1);
               expected_q.push_back(r);
            end
            in_progress = 1'b1;
            byte_count  = 0;
            resp_crc    = CRC_INIT;
            ms_count    = '0;
            return 1'b1;
         end
         if (!in_progress || c == CMD_UNUSED) return 1'b0;
         if (c == CMD_TICK) begin
            if (ms_count != 16'hFFFF) ms_count++;
            if (ms_count >= timeout_limit) close_reading(ST_TIMEOUT);
            return 1'b1;
         end
         if (ms_count >= timeout_limit) begin
            close_reading(ST_TIMEOUT);
            return 1'b1;
         end
         if (byte_count >= 3 && byte_count <= 9) payload[byte_count - 3] = b;
         if (byte_count < 9) resp_crc = crc16_update(resp_crc, b);
         if (byte_count >= RESP_LEN - 1) begin
            close_reading(({b, payload[6]} == resp_crc) ? ST_OK : ST_CRC_ERR);
            return 1'b1;
         end
         byte_count++;
         return 1'b1;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) begin
            report($sformatf("result %0d %s got %h expected %h", result_count, name, got, want));
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected (%h)", result_count, got));
         end else begin
            want = expected_q.pop_front();
            compare_field("tx_valid", 16'(got.tx_valid), 16'(want.tx_valid));
            compare_field("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
            compare_field("tx_last", 16'(got.tx_last), 16'(want.tx_last));
            compare_field("done_res", 16'(got.done_res), 16'(want.done_res));
            compare_field("status", 16'(got.status), 16'(want.status));
            compare_field("moisture_tenths", got.moisture_tenths, want.moisture_tenths);
            compare_field("temperature_tenths", got.temperature_tenths,
                          want.temperature_tenths);
            compare_field("conductivity", got.conductivity, want.conductivity);
         end
         result_count++;
      endtask
   endclass

   // kinds of reading the random part generates
   typedef enum {READ_GOOD, READ_BAD_CRC, READ_ABANDON, READ_TIMEOUT, READ_NOISE}
      reading_kind_type;
   // receiver ready patterns
   typedef enum {PACE_FULL, PACE_MOSTLY, PACE_SPARSE, PACE_EVERY_THIRD} rsp_pace_type;

   logic clock;
   logic reset;

   msrt_req_if req_bus ();
   msrt_rsp_if rsp_bus ();
   msrt_csr_if csr_bus ();

   modbus_sensor_read_transaction u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   reading_scoreboard_type sb;
   int burst_left   = 0;     // transfers left in the current sender burst
   int sent_items   = 0;     // accepted input transfers of any kind
   int tick_pct     = 0;     // chance of a tick before each response byte
   int noise_pct    = 0;     // chance of an unused command before each byte
   bit hold_off_start = 1'b0; // asks the receiver for one long stall

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver: checks every result transfer and paces ready on its own pattern
   initial begin
      int           mode_left;
      int           hold_left;
      rsp_pace_type pace;
      rsp_type      got;
      rsp_bus.ready = 1'b0;
      mode_left = 0;
      hold_left = 0;
      pace = PACE_FULL;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.tx_valid           = rsp_bus.tx_valid;
            got.tx_byte            = rsp_bus.tx_byte;
            got.tx_last            = rsp_bus.tx_last;
            got.done_res           = rsp_bus.done_res;
            got.status             = rsp_bus.status;
            got.moisture_tenths    = rsp_bus.moisture_tenths;
            got.temperature_tenths = rsp_bus.temperature_tenths;
            got.conductivity       = rsp_bus.conductivity;
            sb.check_result(got);
         end
         // long stall so the block backs up into its input
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            pace = rsp_pace_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (pace)
               PACE_FULL:        rsp_bus.ready <= 1'b1;
               PACE_MOSTLY:      rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               PACE_SPARSE:      rsp_bus.ready <= ($urandom_range(0, 9) < 3);
               PACE_EVERY_THIRD: rsp_bus.ready <= (mode_left % 3 == 0);
               default:          rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   // one input transfer; the sender works in bursts separated by random gaps
   task automatic send_item(input cmd_type c, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= c;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      void'(sb.note_request(c, b));
      sent_items++;
      burst_left--;
   endtask

   // sender pauses until every expected result is back, then lets the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // writes both registers back to back; upper data bits of the address write are junk
   task automatic write_regs(input logic [7:0] addr, input logic [15:0] limit);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_DEV_ADDR;
      csr_bus.data  <= {8'($urandom_range(0, 255)), addr};
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_register(CSR_DEV_ADDR, csr_bus.data);
      csr_bus.index <= CSR_TIMEOUT;
      csr_bus.data  <= limit;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_register(CSR_TIMEOUT, limit);
      csr_bus.valid <= 1'b0;
   endtask

   // crc over the nine covered response bytes
   function automatic logic [15:0] response_crc(input logic [7:0] frame_bytes [11]);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < 9; i++) begin
         c = reading_scoreboard_type::crc16_update(c, frame_bytes[i]);
      end
      return c;
   endfunction

   // first count bytes of a response, with ticks and unused commands mixed in
   task automatic send_response(input logic [7:0] frame_bytes [11], input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < tick_pct) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 99) < noise_pct) begin
            send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
         end
         send_item(CMD_RX_BYTE, frame_bytes[i]);
      end
   endtask

   // one random reading: mostly well formed, some corrupted, cut short or timed out
   task automatic run_reading();
      logic [7:0]       frame_bytes [11];
      logic [15:0]      crc;
      reading_kind_type kind;
      int               pick;
      int               idx;
      pick = $urandom_range(0, 99);
      if (pick < 55)      kind = READ_GOOD;
      else if (pick < 75) kind = READ_BAD_CRC;
      else if (pick < 85) kind = READ_ABANDON;
      else if (pick < 95) kind = READ_TIMEOUT;
      else                kind = READ_NOISE;
      // a timeout needs the limit to be reachable in reasonable time
      if (kind == READ_TIMEOUT && sb.timeout_limit > 64) kind = READ_ABANDON;

      if (kind == READ_NOISE) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
               0:       send_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
               1:       send_item(CMD_TICK, 8'($urandom_range(0, 255)));
               default: send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom_range(0, 255));
         // half the time a realistic header; it is not checked either way
         if ($urandom_range(0, 1)) begin
            frame_bytes[0] = sb.dev_addr;
            frame_bytes[1] = FUNC_READ_HOLD;
            frame_bytes[2] = 8'd6;
         end
         crc = response_crc(frame_bytes);
         frame_bytes[9]  = crc[7:0];
         frame_bytes[10] = crc[15:8];
         send_item(CMD_START, 8'($urandom_range(0, 255)));
         case (kind)
            READ_GOOD: send_response(frame_bytes, 11);
            READ_BAD_CRC: begin
               // single bit errors, or a changed high crc byte, are always caught by the crc
               idx = $urandom_range(0, 10);
               if ($urandom_range(0, 1)) begin
                  frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
               end else begin
                  frame_bytes[10] = frame_bytes[10] ^ 8'($urandom_range(1, 255));
               end
               send_response(frame_bytes, 11);
            end
            // left hanging, the next start abandons it
            READ_ABANDON: send_response(frame_bytes, $urandom_range(0, 10));
            default: begin
               send_response(frame_bytes, $urandom_range(0, 10));
               repeat (sb.timeout_limit + 1) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   // main stimulus
   initial begin
      logic [7:0]  frame_bytes [11];
      logic [15:0] crc;
      logic [7:0]  addr;
      logic [15:0] limit;
      int          phase_goal;

      sb = new();
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_RX_BYTE;
      req_bus.rx_byte = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_DEV_ADDR;
      csr_bus.data    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle byte, idle tick and unused command are dropped
      tick_pct  = 0;
      noise_pct = 0;
      send_item(CMD_RX_BYTE, 8'h00);
      send_item(CMD_TICK, 8'hFF);
      send_item(CMD_UNUSED, 8'h5A);

      // clean reading at reset register values, words at their extremes
      frame_bytes = '{8'h01, 8'h03, 8'h06, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00};
      crc = response_crc(frame_bytes);
      frame_bytes[9]  = crc[7:0];
      frame_bytes[10] = crc[15:8];
      send_item(CMD_START, 8'h00);
      send_response(frame_bytes, 11);

      // unused command while busy, then a restart that drops the open reading
      send_item(CMD_START, 8'hFF);
      send_item(CMD_RX_BYTE, 8'hFF);
      send_item(CMD_UNUSED, 8'h00);
      send_item(CMD_START, 8'h00);
      send_item(CMD_TICK, 8'h00);
      drain();

      // timeout by ticks with a short limit
      write_regs(8'hFF, 16'd2);
      send_item(CMD_START, 8'h00);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TICK, 8'h00);
      drain();

      // zero limit: the first byte is discarded and the reading times out
      write_regs(8'h00, 16'd0);
      send_item(CMD_START, 8'h00);
      send_item(CMD_RX_BYTE, 8'hA5);
      drain();

      // random phases, each with its own register setting
      noise_pct  = 3;
      phase_goal = sent_items;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               addr = 8'($urandom_range(2, 254));
               limit = 16'($urandom_range(500, 3000));
               tick_pct = 10;
            end
            1: begin
               addr = 8'h00;
               limit = 16'd0;
               tick_pct = 10;
            end
            2: begin
               addr = 8'hFF;
               limit = 16'hFFFF;
               tick_pct = 20;
            end
            3: begin
               addr = 8'($urandom_range(0, 255));
               limit = 16'($urandom_range(1, 12));
               tick_pct = 12;
            end
            4: begin
               addr = 8'($urandom_range(0, 255));
               limit = 16'($urandom_range(20, 60));
               tick_pct = 25;
            end
            default: begin
               addr = DEV_ADDR_RESET;
               limit = TIMEOUT_RESET;
               tick_pct = 5;
            end
         endcase
         write_regs(addr, limit);
         // no timeouts here, so the output backs up while the receiver holds off
         if (phase == 2) hold_off_start = 1'b1;
         phase_goal += 65;
         while (sent_items < phase_goal) run_reading();
         drain();
      end

      repeat (30) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### modbus_sensor_read_transaction.f
rtl/msrt_pkg.sv
rtl/msrt_if.sv
rtl/modbus_sensor_read_transaction.sv
dv/modbus_sensor_read_transaction_test.sv
